[hdl/idq_pkg.sv]
// idq_pkg: shared types and constants for the instruction dispatch queue
// used by idq_cell and instruction_dispatch_queue; no dependencies

package idq_pkg;

  localparam int OPCODE_W  = 10;
  localparam int OPERAND_W = 16;

  // opcode class boundaries
  localparam logic [OPCODE_W-1:0] CLASS_MEM_LOW    = 10'd200;
  localparam logic [OPCODE_W-1:0] CLASS_BRANCH_LOW = 10'd300;
  localparam logic [OPCODE_W-1:0] CLASS_BRANCH_END = 10'd400;

  // operation codes carried on in_tuser
  typedef enum logic {
    OP_INSERT   = 1'b0,
    OP_DISPATCH = 1'b1
  } op_t;

  // one queue slot
  typedef struct packed {
    logic [OPCODE_W-1:0]  opcode;
    logic [OPERAND_W-1:0] dest;
    logic [OPERAND_W-1:0] src_a;
    logic [OPERAND_W-1:0] src_b;
  } slot_t;

  // per-transaction control broadcast to every cell
  typedef struct packed {
    logic insert;
    logic dispatch;
  } cell_ctrl_t;

  // issue readiness of the class that an opcode belongs to
  function automatic logic class_ready(input logic [OPCODE_W-1:0] opcode,
                                       input logic alu_idle,
                                       input logic mem_free,
                                       input logic branch_free);
    logic rdy;
    if (opcode < CLASS_MEM_LOW) begin
      rdy = alu_idle;
    end else if (opcode < CLASS_BRANCH_LOW) begin
      rdy = mem_free;
    end else if (opcode < CLASS_BRANCH_END) begin
      rdy = branch_free;
    end else begin
      rdy = 1'b0;
    end
    return rdy;
  endfunction

endpackage

[hdl/idq_cell.sv]
// idq_cell: one slot of the dispatch queue, shifts down from its upper neighbor
// depends on idq_pkg

module idq_cell
  import idq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctrl_t          ctrl,
  input  logic [OPCODE_W-1:0] empty_code,
  input  slot_t               new_slot,
  input  slot_t               upper_slot,
  input  logic                claim_in,
  output logic                claim_out,
  output slot_t               slot_q,
  output slot_t               slot_nxt
);

  slot_t slot_r;
  logic  is_empty;

  // emptiness is judged against the live empty code
  assign is_empty  = (slot_r.opcode == empty_code);
  assign claim_out = claim_in | is_empty;

  // shift, take the new instruction, or hold
  always_comb begin
    if (ctrl.dispatch) begin
      slot_nxt = upper_slot;
    end else if (ctrl.insert && !claim_in && is_empty) begin
      slot_nxt = new_slot;
    end else begin
      slot_nxt = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_q = slot_r;

endmodule

[hdl/instruction_dispatch_queue.sv]
// instruction_dispatch_queue: in-order instruction queue built as a row of slot cells
// depends on idq_pkg and idq_cell
//
// channel | ports          | payload (low bit first)
// --------+----------------+-------------------------------------------------------
// input   | in_t*          | tdata: opcode_in, dest_in, src_a_in, src_b_in,
//         |                |        alu_idle, mem_free, branch_free; tuser: op
// result  | out_t*         | tdata: opcode_out, dest_out, src_a_out, src_b_out,
//         |                |        insert_dropped, queue_full, head_ready
// config  | cfg_wr_*       | empty_code
//
// one transaction per clock unless a result waits on out_tready: every cell updates in the
// accepting cycle and the result is registered, visible the next cycle. the free-slot search
// ripples through the cell row in that same cycle. a result waiting on out_tready stops new
// input only if it is not taken in the same cycle. synchronous reset clears every slot and
// the empty code to zero.

module instruction_dispatch_queue
  import idq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // opcode_in, dest_in, src_a_in, src_b_in, alu_idle,
                                  // mem_free, branch_free, zero fill
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // opcode_out, dest_out, src_a_out, src_b_out,
                                  // insert_dropped, queue_full, head_ready, zero fill
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data // empty_code
);

  logic [OPCODE_W-1:0] empty_code_r;
  logic                out_valid_r;
  logic [63:0]         out_data_r;
  logic [63:0]         out_data_nxt;

  logic       accept;
  op_t        op;
  slot_t      new_slot;
  logic       alu_idle;
  logic       mem_free;
  logic       branch_free;
  cell_ctrl_t ctrl;

  slot_t [QUEUE_DEPTH-1:0] slot_q;
  slot_t [QUEUE_DEPTH-1:0] slot_nxt;
  slot_t [QUEUE_DEPTH-1:0] upper;
  logic  [QUEUE_DEPTH:0]   claim;

  // input unpacking
  assign op             = op_t'(in_tuser);
  assign new_slot.opcode = in_tdata[9:0];
  assign new_slot.dest   = in_tdata[25:10];
  assign new_slot.src_a  = in_tdata[41:26];
  assign new_slot.src_b  = in_tdata[57:42];
  assign alu_idle        = in_tdata[58];
  assign mem_free        = in_tdata[59];
  assign branch_free     = in_tdata[60];

  // handshake
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign ctrl.insert   = accept && (op == OP_INSERT);
  assign ctrl.dispatch = accept && (op == OP_DISPATCH);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_code_r <= '0;
    end else if (cfg_wr_en) begin
      empty_code_r <= cfg_wr_data;
    end
  end

  // cell row; the top cell shifts in an empty opcode and keeps its operands
  assign claim[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_top
      assign upper[i].opcode = empty_code_r;
      assign upper[i].dest   = slot_q[i].dest;
      assign upper[i].src_a  = slot_q[i].src_a;
      assign upper[i].src_b  = slot_q[i].src_b;
    end else begin : g_mid
      assign upper[i] = slot_q[i+1];
    end

    idq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .empty_code (empty_code_r),
      .new_slot   (new_slot),
      .upper_slot (upper[i]),
      .claim_in   (claim[i]),
      .claim_out  (claim[i+1]),
      .slot_q     (slot_q[i]),
      .slot_nxt   (slot_nxt[i])
    );
  end

  // result assembly: dispatched head from pre-step state, full and ready from post-step
  always_comb begin
    out_data_nxt = '0;
    if (op == OP_DISPATCH) begin
      out_data_nxt[9:0]   = slot_q[0].opcode;
      out_data_nxt[25:10] = slot_q[0].dest;
      out_data_nxt[41:26] = slot_q[0].src_a;
      out_data_nxt[57:42] = slot_q[0].src_b;
    end else begin
      out_data_nxt[58] = !claim[QUEUE_DEPTH];
    end
    out_data_nxt[59] = (slot_nxt[QUEUE_DEPTH-1].opcode != empty_code_r);
    out_data_nxt[60] = class_ready(slot_nxt[0].opcode, alu_idle, mem_free, branch_free);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[tb/sv/instruction_dispatch_queue_tb.sv]
// instruction_dispatch_queue_tb: self-checking stream testbench for the dispatch queue
// holds a queue model class that predicts every result, plus stimulus and stall drivers
// depends on idq_pkg and the instruction_dispatch_queue rtl
`timescale 1ns / 1ps

// one input transaction, unpacked
typedef struct {
  idq_pkg::op_t op;
  logic [9:0]   opcode;
  logic [15:0]  dest;
  logic [15:0]  src_a;
  logic [15:0]  src_b;
  logic         alu_idle;
  logic         mem_free;
  logic         branch_free;
} idq_step_t;

// one result transaction, unpacked
typedef struct {
  logic [9:0]  opcode;
  logic [15:0] dest;
  logic [15:0] src_a;
  logic [15:0] src_b;
  logic        dropped;
  logic        full;
  logic        ready;
} idq_result_t;

class dispatch_queue_model;
  localparam int DEPTH = 8;

  idq_pkg::slot_t slots [DEPTH];
  logic [9:0]     empty_code;
  idq_result_t    expected_results [$];
  int             errors;

  function new();
    foreach (slots[i]) slots[i] = '0;
    empty_code = '0;
    errors = 0;
  endfunction

  // readiness of the unit serving the head opcode's class
  function logic unit_ready(logic [9:0] opc, logic alu, logic mem, logic br);
    if (opc < idq_pkg::CLASS_MEM_LOW) return alu;
    if (opc < idq_pkg::CLASS_BRANCH_LOW) return mem;
    if (opc < idq_pkg::CLASS_BRANCH_END) return br;
    return 1'b0;
  endfunction

  // advance the queue by one accepted transaction and queue its result
  function void note_step(idq_step_t s);
    idq_result_t r;
    bit placed;
    r = '{default: '0};
    placed = 0;
    if (s.op == idq_pkg::OP_INSERT) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (!placed && slots[i].opcode == empty_code) begin
          slots[i] = '{opcode: s.opcode, dest: s.dest, src_a: s.src_a, src_b: s.src_b};
          placed = 1;
        end
      end
      r.dropped = !placed;
    end else begin
      r.opcode = slots[0].opcode;
      r.dest   = slots[0].dest;
      r.src_a  = slots[0].src_a;
      r.src_b  = slots[0].src_b;
      for (int i = 0; i < DEPTH - 1; i++) slots[i] = slots[i+1];
      // top slot keeps its stale operands
      slots[DEPTH-1].opcode = empty_code;
    end
    r.full  = (slots[DEPTH-1].opcode != empty_code);
    r.ready = unit_ready(slots[0].opcode, s.alu_idle, s.mem_free, s.branch_free);
    expected_results.push_back(r);
  endfunction

  function void compare_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      errors++;
    end
  endfunction

  // compare one accepted result against the oldest prediction
  function void check_result(logic [63:0] d);
    idq_result_t r;
    if (expected_results.size() == 0) begin
      $error("result transaction with nothing expected: %h", d);
      errors++;
      return;
    end
    r = expected_results.pop_front();
    compare_field("opcode_out", r.opcode, d[9:0]);
    compare_field("dest_out", r.dest, d[25:10]);
    compare_field("src_a_out", r.src_a, d[41:26]);
    compare_field("src_b_out", r.src_b, d[57:42]);
    compare_field("insert_dropped", r.dropped, d[58]);
    compare_field("queue_full", r.full, d[59]);
    compare_field("head_ready", r.ready, d[60]);
  endfunction
endclass

module instruction_dispatch_queue_tb;
  import idq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 305;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [9:0]  cfg_wr_data = '0;

  dispatch_queue_model queue_model;
  int burst_left = 0;

  instruction_dispatch_queue #(.QUEUE_DEPTH(8)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver stall pattern, switching to a random mode whenever stall_cyc[6:0] returns to zero
  logic [1:0]  stall_mode = 2'd0;
  logic [15:0] stall_cyc = '0;
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 16'd1;
    if (stall_cyc[6:0] == 7'd0) begin
      stall_mode <= 2'($urandom_range(0, 3));
    end
    case (stall_mode)
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= 1'($urandom_range(0, 1));
      2'd2: out_tready <= (stall_cyc % 3) != 0;
      default: out_tready <= stall_cyc[3:0] < 4'd10;
    endcase
  end

  // result checking and watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        queue_model.check_result(out_tdata);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic idq_step_t make_step(op_t op, logic [9:0] opc, logic [15:0] dest,
                                          logic [15:0] a, logic [15:0] b,
                                          logic [2:0] units);
    idq_step_t s;
    s = '{op: op, opcode: opc, dest: dest, src_a: a, src_b: b,
          alu_idle: units[0], mem_free: units[1], branch_free: units[2]};
    return s;
  endfunction

  // opcode biased toward the empty code and the class boundaries
  function automatic logic [9:0] pick_opcode();
    logic [9:0] edges [8];
    edges = '{10'd0, 10'd199, 10'd200, 10'd299, 10'd300, 10'd399, 10'd400, 10'd1023};
    case ($urandom_range(0, 7))
      0: return queue_model.empty_code;
      1: return edges[$urandom_range(0, 7)];
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic idq_step_t random_step(int insert_pct);
    op_t op;
    op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DISPATCH;
    return make_step(op, pick_opcode(), 16'($urandom), 16'($urandom), 16'($urandom),
                     3'($urandom_range(0, 7)));
  endfunction

  // drive one transaction, with a random gap when a burst ends
  task automatic send(idq_step_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= s.op;
    in_tdata  <= {3'b000, s.branch_free, s.mem_free, s.alu_idle,
                  s.src_b, s.src_a, s.dest, s.opcode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    queue_model.note_step(s);
  endtask

  // stop sending and let every expected result drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (queue_model.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_empty_code(logic [9:0] code);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= code;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    queue_model.empty_code = code;
    @(posedge clk);
  endtask

  initial begin
    logic [9:0] codes [6];
    logic [9:0] class_edges [7];
    int seg_left;
    int insert_pct;

    queue_model = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: dispatch from an empty queue
    send(make_step(OP_DISPATCH, 10'd5, 16'h1234, 16'h5678, 16'h9abc, 3'b111));
    // fill with class boundary opcodes and operand extremes
    class_edges = '{10'd199, 10'd200, 10'd299, 10'd300, 10'd399, 10'd400, 10'd1023};
    foreach (class_edges[i]) begin
      send(make_step(OP_INSERT, class_edges[i], i[0] ? 16'hffff : 16'h0000,
                     i[0] ? 16'h0000 : 16'hffff, 16'hffff, 3'(i)));
    end
    // the empty code lands in the top slot but it still counts as free
    send(make_step(OP_INSERT, 10'd0, 16'hffff, 16'hffff, 16'hffff, 3'b010));
    send(make_step(OP_INSERT, 10'd1, 16'h0000, 16'h0000, 16'h0000, 3'b100));
    // queue full, insert is dropped
    send(make_step(OP_INSERT, 10'd5, 16'haaaa, 16'h5555, 16'h0f0f, 3'b001));
    // drain past empty, exposing stale operands of the top slot
    for (int i = 0; i < 10; i++) begin
      send(make_step(OP_DISPATCH, 10'h3ff, 16'hffff, 16'hffff, 16'hffff, 3'(i)));
    end
    settle();

    // random phases, each under its own empty code
    codes = '{10'd1023, 10'($urandom_range(0, 1023)), 10'd200, 10'd0,
              10'($urandom_range(0, 1023)), 10'd399};
    foreach (codes[p]) begin
      write_empty_code(codes[p]);
      seg_left = 0;
      insert_pct = 50;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // alternate fill-heavy, drain-heavy and balanced stretches
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 40);
          case ($urandom_range(0, 2))
            0: insert_pct = 20;
            1: insert_pct = 50;
            default: insert_pct = 85;
          endcase
        end
        seg_left--;
        send(random_step(insert_pct));
      end
      settle();
    end

    if (queue_model.errors == 0 && queue_model.expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
